### hw/rtl/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, constants and the bytewise crc-32 update for the deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CrcW     = 32;
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 3;

    localparam logic [ByteW-1:0] MarkerReset = 8'hAE;
    localparam logic [CrcW-1:0]  CrcPoly     = 32'hEDB8_8320;
    localparam logic [CrcW-1:0]  CrcInit     = 32'hFFFF_FFFF;

    // index of the last expected-crc byte (four bytes, lsb first)
    localparam logic [1:0] CrcLastIdx = 2'd3;

    // register word index on the configuration port
    localparam logic RegStartMarker = 1'b0;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             byte_valid;
        logic             frame_end;
        logic             crc_match;
        logic             stray_byte;
    } crcdf_result_t;

    // reflected crc-32, one byte in, eight bit steps
    function automatic logic [CrcW-1:0] crc_add_byte(input logic [CrcW-1:0] crc_in,
                                                     input logic [ByteW-1:0] data);
        logic [CrcW-1:0] crc;
        crc = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
        for (int k = 0; k < ByteW; k++) begin
            crc = (crc >> 1) ^ (crc[0] ? CrcPoly : '0);
        end
        return crc;
    endfunction

endpackage

### hw/rtl/crcdf_apb_regs.sv
// ----------------------------------------------------------------------------
// crcdf_apb_regs
// APB register file holding the start marker byte.
// ----------------------------------------------------------------------------
module crcdf_apb_regs
    import crcdf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    output logic [ByteW-1:0]    start_marker
);

    logic [ByteW-1:0] marker_reg;
    logic             wr_en;

    // word index is paddr[2]; low bits select nothing
    assign wr_en  = psel && penable && pwrite && (paddr[2] == RegStartMarker);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MarkerReset;
        end
        else if (wr_en)
        begin
            marker_reg <= pwdata[ByteW-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            RegStartMarker: prdata = {{(ApbDataW-ByteW){1'b0}}, marker_reg};
            default:        prdata = '0;
        endcase
    end

    assign start_marker = marker_reg;

endmodule

### hw/rtl/crcdf_parser.sv
// ----------------------------------------------------------------------------
// crcdf_parser
// Frame phase tracking, expected-crc capture and running crc over payload.
// ----------------------------------------------------------------------------
module crcdf_parser
    import crcdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ByteW-1:0] data,
    input  logic [ByteW-1:0] start_marker,
    output crcdf_result_t    res,
    output logic             res_valid
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_CRC,
        PH_PAYLOAD
    } phase_t;

    phase_t           phase_reg,    phase_next;
    logic [ByteW-1:0] length_reg,   length_next;
    logic [1:0]       crc_idx_reg,  crc_idx_next;
    logic [CrcW-1:0]  exp_crc_reg,  exp_crc_next;
    logic [CrcW-1:0]  run_crc_reg,  run_crc_next;
    logic [ByteW-1:0] count_reg,    count_next;

    logic [CrcW-1:0]  crc_upd;
    logic [ByteW-1:0] count_inc;

    assign crc_upd   = crc_add_byte(run_crc_reg, data);
    assign count_inc = ByteW'(count_reg + 1'b1);

    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        crc_idx_next = crc_idx_reg;
        exp_crc_next = exp_crc_reg;
        run_crc_next = run_crc_reg;
        count_next   = count_reg;
        res          = '0;
        res_valid    = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (data == start_marker)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        res.stray_byte = 1'b1;
                        res_valid      = 1'b1;
                    end
                end
                PH_LENGTH:
                begin
                    length_next  = data;
                    crc_idx_next = '0;
                    exp_crc_next = '0;
                    run_crc_next = CrcInit;
                    count_next   = '0;
                    phase_next   = PH_CRC;
                end
                PH_CRC:
                begin
                    exp_crc_next = exp_crc_reg
                                 | ({{(CrcW-ByteW){1'b0}}, data} << {crc_idx_reg, 3'b000});
                    crc_idx_next = 2'(crc_idx_reg + 1'b1);
                    if (crc_idx_reg == CrcLastIdx)
                    begin
                        if (length_reg == '0)
                        begin
                            // empty frame closes on the last crc byte
                            phase_next    = PH_IDLE;
                            res.frame_end = 1'b1;
                            res.crc_match = ((run_crc_reg ^ CrcInit) == exp_crc_next);
                            res_valid     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    run_crc_next   = crc_upd;
                    count_next     = count_inc;
                    res.out_byte   = data;
                    res.byte_valid = 1'b1;
                    res_valid      = 1'b1;
                    if (count_inc == length_reg)
                    begin
                        phase_next    = PH_IDLE;
                        res.frame_end = 1'b1;
                        res.crc_match = ((crc_upd ^ CrcInit) == exp_crc_reg);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            length_reg  <= '0;
            crc_idx_reg <= '0;
            exp_crc_reg <= '0;
            run_crc_reg <= CrcInit;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            crc_idx_reg <= crc_idx_next;
            exp_crc_reg <= exp_crc_next;
            run_crc_reg <= run_crc_next;
            count_reg   <= count_next;
        end
    end

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step)
        else $error("parser result without an input byte");

    a_match_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.crc_match) |-> res.frame_end)
        else $error("crc match flagged off a frame end");

    a_length_then_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_LENGTH) |=> (phase_reg == PH_CRC && crc_idx_reg == '0))
        else $error("length byte did not lead to crc capture");

    a_payload_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (length_reg != '0))
        else $error("payload phase entered with zero length");

endmodule

### hw/rtl/crc32_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// crc32_packet_deframer_core
// Length-prefixed frame receiver with crc-32 check, bytes passed through.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  input    | in_valid / in_ready       | in_byte
//  output   | out_valid / out_ready     | out_byte, byte_valid, frame_end,
//           |                           | crc_match, stray_byte
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
//  one byte per cycle unless the output stalls; input and result registered
//  throughput is set by the bytewise crc update and phase step
//  rst_n clears the phase, counters, crc state and both stage valids;
//  the start marker resets to 0xae
//  a result held at the output stalls the parser; one more byte is still
//  taken into the input register before in_ready drops
// ----------------------------------------------------------------------------
module crc32_packet_deframer_core
    import crcdf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ByteW-1:0]    in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ByteW-1:0]    out_byte,
    output logic                byte_valid,
    output logic                frame_end,
    output logic                crc_match,
    output logic                stray_byte,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    logic [ByteW-1:0] start_marker;
    logic             s1_valid_reg;
    logic [ByteW-1:0] s1_byte_reg;
    logic             out_valid_reg;
    crcdf_result_t    out_res_reg;
    logic             out_free;
    logic             s1_adv;
    crcdf_result_t    res;
    logic             res_valid;

    crcdf_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start_marker (start_marker)
    );

    // parser steps only when the output slot can take whatever it makes
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    crcdf_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_adv),
        .data         (s1_byte_reg),
        .start_marker (start_marker),
        .res          (res),
        .res_valid    (res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_res_reg.out_byte;
    assign byte_valid = out_res_reg.byte_valid;
    assign frame_end  = out_res_reg.frame_end;
    assign crc_match  = out_res_reg.crc_match;
    assign stray_byte = out_res_reg.stray_byte;

endmodule

### bench/tb_crc32_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_crc32_packet_deframer_core
// Self-checking bench for the length-prefixed crc-32 frame receiver. Random
// byte streams made mostly of well-formed frames, with noise and cut-off
// frames mixed in, are fed through valid/ready with random idling on both
// sides. A scoreboard tracks the parser state and running crc, and checks
// every passed-through byte, frame end and stray flag. The start marker is
// rewritten over the apb port between phases and read back.
// ----------------------------------------------------------------------------
module tb_crc32_packet_deframer_core;
    import crcdf_pkg::*;

    typedef enum logic [1:0] {
        SEEK_MARKER,
        TAKE_LENGTH,
        TAKE_CRC,
        TAKE_PAYLOAD
    } parse_phase_t;

    class deframer_scoreboard;
        logic [ByteW-1:0] start_marker;
        parse_phase_t     phase;
        logic [ByteW-1:0] frame_len;
        logic [1:0]       crc_idx;
        logic [CrcW-1:0]  exp_crc;
        logic [CrcW-1:0]  run_crc;
        logic [ByteW-1:0] pay_cnt;
        crcdf_result_t    pending[$];
        int               errors;

        function new();
            start_marker = MarkerReset;
            phase        = SEEK_MARKER;
            frame_len    = '0;
            crc_idx      = '0;
            exp_crc      = '0;
            run_crc      = CrcInit;
            pay_cnt      = '0;
            errors       = 0;
        endfunction

        // bit-serial reflected crc, lsb of the data byte first
        static function logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
            logic [CrcW-1:0] c;
            logic            fb;
            c = crc;
            for (int i = 0; i < ByteW; i++)
            begin
                fb = c[0] ^ data[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ CrcPoly;
            end
            return c;
        endfunction

        function void note_byte(input logic [ByteW-1:0] b);
            crcdf_result_t r;
            r = '0;
            case (phase)
                SEEK_MARKER:
                begin
                    if (b == start_marker)
                        phase = TAKE_LENGTH;
                    else
                    begin
                        r.stray_byte = 1'b1;
                        pending.push_back(r);
                    end
                end
                TAKE_LENGTH:
                begin
                    frame_len = b;
                    crc_idx   = '0;
                    exp_crc   = '0;
                    run_crc   = CrcInit;
                    pay_cnt   = '0;
                    phase     = TAKE_CRC;
                end
                TAKE_CRC:
                begin
                    exp_crc[crc_idx*8 +: 8] = b;
                    crc_idx = crc_idx + 2'd1;
                    if (crc_idx == 2'd0)
                    begin
                        if (frame_len == 0)
                        begin
                            // empty frame closes on the last crc byte
                            r.frame_end = 1'b1;
                            r.crc_match = (~run_crc == exp_crc);
                            pending.push_back(r);
                            phase = SEEK_MARKER;
                        end
                        else
                            phase = TAKE_PAYLOAD;
                    end
                end
                default:
                begin
                    run_crc      = crc_step(run_crc, b);
                    pay_cnt      = pay_cnt + 8'd1;
                    r.out_byte   = b;
                    r.byte_valid = 1'b1;
                    if (pay_cnt == frame_len)
                    begin
                        r.frame_end = 1'b1;
                        r.crc_match = (~run_crc == exp_crc);
                        phase       = SEEK_MARKER;
                    end
                    pending.push_back(r);
                end
            endcase
        endfunction

        function void check_field(input string name, input logic [ByteW-1:0] want,
                                  input logic [ByteW-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input crcdf_result_t got);
            crcdf_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_valid", ByteW'(want.byte_valid), ByteW'(got.byte_valid));
            check_field("frame_end", ByteW'(want.frame_end), ByteW'(got.frame_end));
            check_field("crc_match", ByteW'(want.crc_match), ByteW'(got.crc_match));
            check_field("stray_byte", ByteW'(want.stray_byte), ByteW'(got.stray_byte));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [ByteW-1:0]    in_byte   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ByteW-1:0]    out_byte;
    logic                byte_valid;
    logic                frame_end;
    logic                crc_match;
    logic                stray_byte;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ApbAddrW-1:0] paddr     = '0;
    logic [ApbDataW-1:0] pwdata    = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int tx_idle_pct  = 38;
    int rx_idle_pct  = 38;
    int hold_request = 0;
    int hold_left    = 0;
    int bytes_sent   = 0;

    deframer_scoreboard sb = new();

    crc32_packet_deframer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .frame_end  (frame_end),
        .crc_match  (crc_match),
        .stray_byte (stray_byte),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end

    // input transaction noted before output check so ordering is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_byte);
            if (out_valid && out_ready)
                sb.check_result(crcdf_result_t'({out_byte, byte_valid, frame_end,
                                                 crc_match, stray_byte}));
        end
    end

    // receiver side: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        // let a trailing header byte settle inside the block
        repeat (6) @(posedge clk);
    endtask

    task automatic write_start_marker(input logic [ByteW-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'({RegStartMarker, 2'b00});
        pwdata  <= ApbDataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.start_marker = value;
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[ByteW-1:0] !== value)
        begin
            $display("%0t: start_marker readback, expected %h actual %h",
                     $time, value, prdata[ByteW-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // cut >= 0 sends only the first cut bytes of the frame
    task automatic send_frame(input int len, input bit good, input int cut,
                              input bit marker_fill);
        logic [ByteW-1:0] body[$];
        logic [ByteW-1:0] framed[$];
        logic [CrcW-1:0]  crc;
        crc = CrcInit;
        for (int i = 0; i < len; i++)
        begin
            if (marker_fill || $urandom_range(9) == 0)
                body.push_back(sb.start_marker);
            else
                body.push_back(ByteW'($urandom));
            crc = deframer_scoreboard::crc_step(crc, body[i]);
        end
        crc = ~crc;
        if (!good)
            crc = crc ^ (CrcW'(1) << $urandom_range(CrcW-1));
        framed = {sb.start_marker, ByteW'(len), crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
        framed = {framed, body};
        for (int i = 0; i < framed.size() && (cut < 0 || i < cut); i++)
            send_byte(framed[i]);
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
            if (pick < 75)
                send_frame(len, $urandom_range(3) != 0, -1, 1'b0);
            else if (pick < 85)
                send_frame(len, 1'b1, $urandom_range(1, len + 5), 1'b0);
            else
                repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes, empty frames good and bad, marker as data, bad crc
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 1'b1, -1, 1'b0);
        send_frame(0, 1'b0, -1, 1'b0);
        send_frame(1, 1'b1, -1, 1'b1);
        send_frame(2, 1'b0, -1, 1'b0);

        write_start_marker(8'h00);
        random_traffic(60);

        write_start_marker(8'hFF);
        send_frame(255, 1'b1, -1, 1'b0);
        random_traffic(50);

        // stretch with no idling on either side
        write_start_marker(ByteW'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(60);
        rx_idle_pct = 38;

        // receiver holds off while a full frame is pushed back to back
        hold_request = 150;
        send_frame(40, 1'b1, -1, 1'b0);
        tx_idle_pct = 38;

        write_start_marker(MarkerReset);
        random_traffic(60);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
